@@ src/med3_pkg.sv @@
// Shared types and constants for the 3x3 median filter.
// Holds the compare-exchange schedule of the median network and the item codes.
// No dependencies.
package med3_pkg;

    // Meaning of the input request's tuser bit
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // Kind of work carried by the first pipeline stage
    localparam logic [1:0] K_PASS  = 2'd0;  // small image, sample passes through
    localparam logic [1:0] K_PIX   = 2'd1;  // pixel written to the row store
    localparam logic [1:0] K_DRAIN = 2'd2;  // final row read back

    // Output queue
    localparam int unsigned FIFO_DEPTH = 16;
    localparam int unsigned FIFO_AW    = 4;
    localparam int unsigned FIFO_CW    = 5;

    // Median-of-nine network: 19 compare-exchange steps, median ends in slot 4
    localparam int unsigned NUM_CX = 19;
    localparam logic [3:0] CX_A [NUM_CX] = '{
        4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
        4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
    };
    localparam logic [3:0] CX_B [NUM_CX] = '{
        4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
        4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
    };

    // Nine 8-bit samples of one channel
    typedef logic [8:0][7:0] t_v9;

    // Control carried with an item in the first stage
    typedef struct packed {
        logic [1:0] kind;
        logic       top_prev1;  // second row of the frame: top row replicates
        logic       emit;       // one result for the previous column
        logic       dual;       // row end: a second result for this column
        logic       first;      // first output column of a row or of the drain
        logic       x0;         // column 0 of a row
        logic       fe;         // frame end
    } t_s1_ctl;

    // Apply the network steps first..last to v (lower value into slot a)
    function automatic t_v9 med_steps(t_v9 v, int first, int last);
        t_v9        r;
        logic [7:0] a;
        logic [7:0] b;
        r = v;
        for (int k = 0; k < NUM_CX; k++) begin
            if (k >= first && k <= last) begin
                a = r[CX_A[k]];
                b = r[CX_B[k]];
                if (b < a) begin
                    r[CX_A[k]] = b;
                    r[CX_B[k]] = a;
                end
            end
        end
        return r;
    endfunction

endpackage

@@ src/median_3x3_filter_clamped_edges_unit.sv @@
// 3x3 median filter over raster pixels of up to four 8-bit channels, clamped borders.
// Row store memory, column window registers, pipelined median network, output queue.
// Depends on med3_pkg.

// The block takes one request per clock while its input is not held. A pixel at the end of a
// row carries two results and holds the input while it issues its second one; the first row
// of a frame gives no results and does not hold. The rate is set by the single median
// pipeline, which starts one result per cycle. A result passes the first stage, the median
// stages m0, m1 and m2 and the output queue before it is offered on the output. Input is held
// when the 16-entry output queue plus work in flight could overfill it, and while a row-end
// pixel issues its second result. The row store is one memory of MAX_WIDTH entries, each
// holding the two previous rows at one column, read once and written once per pixel. Its
// contents are undefined after reset and need no clearing pass: every entry is written
// before its contents are used.
// After the last row send W drain requests (tuser high) to get the final output row. Any
// register write restarts the frame.
module median_3x3_filter_clamped_edges_unit #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_chan0, in_chan1, in_chan2, in_chan3
    input  logic        s_axis_tuser,   // func
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_chan0, out_chan1, out_chan2, out_chan3
    output logic        m_axis_tlast    // frame_end
);

    localparam int PW = 8 * MAX_CHANNELS;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int FD = med3_pkg::FIFO_DEPTH;
    localparam int FA = med3_pkg::FIFO_AW;
    localparam int FC = med3_pkg::FIFO_CW;

    typedef logic [2:0][PW-1:0] t_col;   // top, middle, bottom pixel of one column

    // ---------------- configuration registers ----------------
    logic [11:0] r_width;
    logic [15:0] r_height;
    logic [2:0]  r_nch;
    logic        cfg_wr;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_hit = cfg_wr & (paddr[3:2] == med3_pkg::REG_WIDTH
                             || paddr[3:2] == med3_pkg::REG_HEIGHT
                             || paddr[3:2] == med3_pkg::REG_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 16'd480;
            r_nch    <= 3'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                med3_pkg::REG_WIDTH:    r_width  <= pwdata[11:0];
                med3_pkg::REG_HEIGHT:   r_height <= pwdata[15:0];
                med3_pkg::REG_CHANNELS: r_nch    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            med3_pkg::REG_WIDTH:    prdata = {20'd0, r_width};
            med3_pkg::REG_HEIGHT:   prdata = {16'd0, r_height};
            med3_pkg::REG_CHANNELS: prdata = {29'd0, r_nch};
            default:                prdata = 32'd0;
        endcase
    end

    // effective (clamped) settings
    logic [WW-1:0] eff_w;
    logic [15:0]   eff_h;
    logic [2:0]    eff_nch;
    logic [AW-1:0] col_last;
    logic [15:0]   row_last;
    logic          small_img;

    always_comb begin
        if (r_width == 12'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_width);
        end
        eff_h = (r_height == 16'd0) ? 16'd1 : r_height;
        if (r_nch == 3'd0) begin
            eff_nch = 3'd1;
        end else if (32'(r_nch) > 32'(MAX_CHANNELS)) begin
            eff_nch = 3'(MAX_CHANNELS);
        end else begin
            eff_nch = r_nch;
        end
        col_last  = AW'(eff_w - WW'(1));
        row_last  = eff_h - 16'd1;
        small_img = (eff_w < WW'(3)) || (eff_h < 16'd3);
    end

    // ---------------- input pixel, unused channels zeroed ----------------
    logic [PW-1:0] in_pix;

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_in
        assign in_pix[8*c +: 8] = (3'(c) < eff_nch) ? s_axis_tdata[8*c +: 8] : 8'd0;
    end

    // ---------------- position counters and request decode ----------------
    logic [AW-1:0]     r_col;
    logic [15:0]       r_row;
    logic              r_draining;
    logic [AW-1:0]     n_col;
    logic [15:0]       n_row;
    logic              n_draining;
    logic              acc;
    logic              is_drain;
    logic              ld_s1;
    med3_pkg::t_s1_ctl n_s1;
    logic [1:0]        n_add;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              at_end;

    logic              r_s1_vld;
    logic              r_s1_ph2;
    med3_pkg::t_s1_ctl r_s1;
    logic [PW-1:0]     r_s1_pix;
    logic [AW-1:0]     r_s1_x;
    logic              s1_hold;

    logic [FC-1:0]     r_used;
    logic [FC-1:0]     r_cnt;

    // a row-end pixel that carries two results keeps the first stage for its second result
    assign s1_hold = r_s1_vld && r_s1.kind == med3_pkg::K_PIX && r_s1.dual && !r_s1_ph2;
    assign s_axis_tready = (r_used <= FC'(FD - 2)) && !s1_hold;
    assign acc      = s_axis_tvalid & s_axis_tready;
    assign is_drain = (s_axis_tuser == med3_pkg::FUNC_DRAIN);
    assign at_end   = (r_col == col_last);

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_draining = r_draining;
        ld_s1      = 1'b0;
        n_s1       = '0;
        n_add      = 2'd0;
        rd_en      = 1'b0;
        rd_addr    = r_col;
        if (acc) begin
            if (small_img) begin
                // pass-through; drain requests give nothing
                if (!is_drain) begin
                    ld_s1     = 1'b1;
                    n_s1.kind = med3_pkg::K_PASS;
                    n_s1.fe   = at_end && (r_row == row_last);
                    n_add     = 2'd1;
                    if (at_end) begin
                        n_col = '0;
                        n_row = (r_row == row_last) ? 16'd0 : r_row + 16'd1;
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                end
            end else if (r_draining) begin
                // pixels are dropped while the last row drains
                if (is_drain) begin
                    ld_s1      = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = at_end ? r_col : r_col + AW'(1);
                    n_s1.kind  = med3_pkg::K_DRAIN;
                    n_s1.first = (r_col == '0);
                    n_s1.fe    = at_end;
                    n_add      = 2'd1;
                    if (at_end) begin
                        n_col      = '0;
                        n_row      = 16'd0;
                        n_draining = 1'b0;
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                end
            end else if (!is_drain) begin
                ld_s1          = 1'b1;
                rd_en          = 1'b1;
                rd_addr        = r_col;
                n_s1.kind      = med3_pkg::K_PIX;
                n_s1.top_prev1 = (r_row == 16'd1);
                n_s1.emit      = (r_row != 16'd0) && (r_col != '0);
                n_s1.dual      = (r_row != 16'd0) && at_end;
                n_s1.first     = (r_col == AW'(1));
                n_s1.x0        = (r_col == '0);
                n_add          = {1'b0, n_s1.emit} + {1'b0, n_s1.dual};
                if (at_end) begin
                    n_col = '0;
                    if (r_row == row_last) begin
                        n_row      = 16'd0;
                        n_draining = 1'b1;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
        end
        // a register write restarts the frame
        if (cfg_hit) begin
            n_col      = '0;
            n_row      = 16'd0;
            n_draining = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= 16'd0;
            r_draining <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_draining <= n_draining;
        end
    end

    // ---------------- row store: {older row, newer row} per column ----------------
    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_mem_q;
    logic            mem_we;
    logic [PW-1:0]   older;
    logic [PW-1:0]   newer;

    assign older  = r_mem_q[2*PW-1:PW];
    assign newer  = r_mem_q[PW-1:0];
    assign mem_we = r_s1_vld && r_s1.kind == med3_pkg::K_PIX && !r_s1_ph2;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
        if (mem_we) begin
            r_mem[r_s1_x] <= {newer, r_s1_pix};
        end
    end

    // ---------------- first stage: column assembly and window ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_ph2 <= 1'b0;
        end else if (ld_s1) begin
            r_s1_vld <= 1'b1;
            r_s1_ph2 <= 1'b0;
        end else if (s1_hold) begin
            r_s1_ph2 <= 1'b1;
        end else begin
            r_s1_vld <= 1'b0;
            r_s1_ph2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s1) begin
            r_s1     <= n_s1;
            r_s1_pix <= in_pix;
            r_s1_x   <= r_col;
        end
    end

    t_col r_w1;      // column before the newest
    t_col r_w2;      // two columns back
    t_col r_col0;    // column 0 of the last two rows, for the drain start
    t_col col_now;
    t_col win_l;
    t_col win_c;
    t_col win_r;
    logic win_shift;
    logic n_m0_vld;
    logic n_m0_fe;

    always_comb begin
        col_now   = '0;
        win_l     = r_w2;
        win_c     = r_w1;
        win_r     = r_w1;
        win_shift = 1'b0;
        n_m0_vld  = 1'b0;
        n_m0_fe   = 1'b0;
        if (r_s1_vld) begin
            case (r_s1.kind)
                med3_pkg::K_PASS: begin
                    col_now  = {r_s1_pix, r_s1_pix, r_s1_pix};
                    win_l    = col_now;
                    win_c    = col_now;
                    win_r    = col_now;
                    n_m0_vld = 1'b1;
                    n_m0_fe  = r_s1.fe;
                end
                med3_pkg::K_PIX: begin
                    col_now = {r_s1_pix, newer, r_s1.top_prev1 ? newer : older};
                    if (r_s1_ph2) begin
                        // right edge: right column replicates the center
                        win_l    = r_w2;
                        win_c    = r_w1;
                        win_r    = r_w1;
                        n_m0_vld = 1'b1;
                    end else begin
                        win_l     = r_s1.first ? r_w1 : r_w2;
                        win_c     = r_w1;
                        win_r     = col_now;
                        n_m0_vld  = r_s1.emit;
                        win_shift = 1'b1;
                    end
                end
                med3_pkg::K_DRAIN: begin
                    // bottom row replicates the last image row
                    col_now   = {newer, newer, older};
                    win_l     = r_s1.first ? r_col0 : r_w2;
                    win_c     = r_s1.first ? r_col0 : r_w1;
                    win_r     = col_now;
                    n_m0_vld  = 1'b1;
                    n_m0_fe   = r_s1.fe;
                    win_shift = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            r_w2 <= win_c;
            r_w1 <= col_now;
        end
        if (mem_we && r_s1.x0) begin
            r_col0 <= {r_s1_pix, r_s1_pix, newer};
        end
    end

    // ---------------- median pipeline ----------------
    logic                 r_m0_vld;
    logic                 r_m0_fe;
    logic [8:0][PW-1:0]   r_m0_win;
    logic                 r_m1_vld;
    logic                 r_m1_fe;
    logic                 r_m2_vld;
    logic                 r_m2_fe;
    logic [PW-1:0]        med_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else begin
            r_m0_vld <= n_m0_vld;
            r_m1_vld <= r_m0_vld;
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0_fe <= n_m0_fe;
        r_m1_fe <= r_m0_fe;
        r_m2_fe <= r_m1_fe;
        for (int i = 0; i < 3; i++) begin
            r_m0_win[3*i]     <= win_l[i];
            r_m0_win[3*i + 1] <= win_c[i];
            r_m0_win[3*i + 2] <= win_r[i];
        end
    end

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_med
        med3_pkg::t_v9 v0;
        med3_pkg::t_v9 v3;
        med3_pkg::t_v9 r_m1;
        med3_pkg::t_v9 r_m2;

        always_comb begin
            for (int i = 0; i < 9; i++) begin
                v0[i] = r_m0_win[i][8*c +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            r_m1 <= med3_pkg::med_steps(v0, 0, 6);
            r_m2 <= med3_pkg::med_steps(r_m1, 7, 13);
        end

        assign v3 = med3_pkg::med_steps(r_m2, 14, 18);
        assign med_pix[8*c +: 8] = v3[4];
    end

    // ---------------- output queue ----------------
    logic [PW:0]   r_fifo [FD];
    logic [FA-1:0] r_wptr;
    logic [FA-1:0] r_rptr;
    logic          push;
    logic          pop;
    logic [PW:0]   head;

    assign push = r_m2_vld;
    assign pop  = m_axis_tvalid & m_axis_tready;
    assign head = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= {r_m2_fe, med_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FA'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FA'(1);
            end
            r_cnt  <= r_cnt + FC'(push) - FC'(pop);
            // results promised to accepted requests and not yet taken
            r_used <= r_used + FC'(n_add) - FC'(pop);
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tlast  = head[PW];

    for (genvar c = 0; c < 4; c++) begin : g_out
        if (c < MAX_CHANNELS) begin : g_used
            assign m_axis_tdata[8*c +: 8] = head[8*c +: 8];
        end else begin : g_zero
            assign m_axis_tdata[8*c +: 8] = 8'd0;
        end
    end

    // ---------------- checks ----------------
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && r_cnt == FC'(FD)))
        else $error("output queue overflow");

    a_credit_covers_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= r_cnt)
        else $error("queue holds more results than were reserved");

    a_row_end_second : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_hold |=> (r_s1_vld && r_s1_ph2 && !s1_hold))
        else $error("row-end pixel did not issue its second result");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for median_3x3_filter_clamped_edges_unit: stream requests in,
// compare each result with an in-bench prediction of the clamped 3x3 median, per channel.
// Depends on med3_pkg and the filter RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_COLS    = 2048;   // row store depth of the block
    localparam int NUM_CH        = 4;
    localparam int SETTLE_CYCLES = 24;     // covers requests that cause no result
    localparam int STALL_LIMIT   = 3000;   // cycles without any handshake
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int PRINT_LIMIT   = 40;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Request and result streams
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // in_chan0, in_chan1, in_chan2, in_chan3
    logic        s_axis_tuser  = med3_pkg::FUNC_PIXEL;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // out_chan0, out_chan1, out_chan2, out_chan3
    logic        m_axis_tlast;        // frame_end

    median_3x3_filter_clamped_edges_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One filtered pixel as it should leave the block
    typedef struct {
        logic [31:0] chans;
        logic        frame_end;
    } t_filtered_px;

    t_filtered_px median_q[$];

    // Mirror of the registers and of the frame position
    logic [11:0] reg_width  = 12'd640;
    logic [15:0] reg_height = 16'd480;
    logic [2:0]  reg_chans  = 3'd1;
    int          col_cnt    = 0;
    int          row_cnt    = 0;
    int          drain_cnt  = 0;
    int          rot_slot   = 0;
    logic [31:0] row_mem [3][STORE_COLS];

    // Bench controls
    int error_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_serial = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    function automatic int eff_width();
        if (reg_width == 0) return 1;
        if (reg_width > STORE_COLS) return STORE_COLS;
        return int'(reg_width);
    endfunction

    function automatic int eff_height();
        return (reg_height == 0) ? 1 : int'(reg_height);
    endfunction

    function automatic int eff_chans();
        if (reg_chans == 0) return 1;
        if (reg_chans > NUM_CH) return NUM_CH;
        return int'(reg_chans);
    endfunction

    function automatic void restart_frame();
        col_cnt   = 0;
        row_cnt   = 0;
        drain_cnt = 0;
        rot_slot  = 0;
    endfunction

    // Median by rank: the sample with at most four below it and at least five at or below
    function automatic logic [7:0] median_of_nine(logic [8:0][7:0] v);
        int         lt;
        int         le;
        logic [7:0] med;
        med = v[0];
        for (int i = 0; i < 9; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < 9; j++) begin
                if (v[j] < v[i]) lt++;
                if (v[j] <= v[i]) le++;
            end
            if (lt <= 4 && le >= 5) med = v[i];
        end
        return med;
    endfunction

    // Queue the median of column xc over row slots top, mid, bot, clamped at the edges
    function automatic void push_median(int top, int mid, int bot, int xc, int w, logic fe);
        int              cols[3];
        int              slots[3];
        logic [8:0][7:0] win;
        t_filtered_px    r;
        cols[0]  = (xc > 0) ? xc - 1 : 0;
        cols[1]  = xc;
        cols[2]  = (xc + 1 < w) ? xc + 1 : w - 1;
        slots[0] = top;
        slots[1] = mid;
        slots[2] = bot;
        r.chans  = '0;
        for (int c = 0; c < eff_chans(); c++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i * 3 + j] = row_mem[slots[i]][cols[j]][8 * c +: 8];
            r.chans[8 * c +: 8] = median_of_nine(win);
        end
        r.frame_end = fe;
        median_q.push_back(r);
    endfunction

    // Work out the results of one accepted request
    function automatic void predict_request(logic func, logic [31:0] raw);
        int           w;
        int           h;
        int           x;
        int           cur;
        int           m1;
        int           m2;
        logic [31:0]  pix;
        t_filtered_px r;
        w   = eff_width();
        h   = eff_height();
        pix = '0;
        for (int c = 0; c < eff_chans(); c++) pix[8 * c +: 8] = raw[8 * c +: 8];

        // Small image: pass-through, drains ignored
        if (w < 3 || h < 3) begin
            if (func == med3_pkg::FUNC_DRAIN) return;
            r.chans     = pix;
            r.frame_end = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
            median_q.push_back(r);
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) row_cnt = 0;
            end
            return;
        end

        // All rows in: drains give out the last row, pixels are dropped
        if (row_cnt >= h) begin
            if (func == med3_pkg::FUNC_PIXEL) return;
            x = drain_cnt % w;
            push_median((rot_slot + 1) % 3, (rot_slot + 2) % 3, (rot_slot + 2) % 3, x, w,
                        x == w - 1);
            drain_cnt++;
            if (drain_cnt >= w) restart_frame();
            return;
        end

        // Rows still arriving: early drains are ignored
        if (func == med3_pkg::FUNC_DRAIN) return;
        x   = col_cnt % w;
        cur = rot_slot % 3;
        m1  = (cur + 2) % 3;
        m2  = (cur + 1) % 3;
        row_mem[cur][x] = pix;
        if (row_cnt >= 1) begin
            if (x >= 1) push_median((row_cnt == 1) ? m1 : m2, m1, cur, x - 1, w, 1'b0);
            if (x == w - 1) push_median((row_cnt == 1) ? m1 : m2, m1, cur, x, w, 1'b0);
        end
        col_cnt = x + 1;
        if (col_cnt >= w) begin
            col_cnt  = 0;
            row_cnt++;
            rot_slot = (cur + 1) % 3;
        end
    endfunction

    task automatic report(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input logic [31:0] data, input logic last);
        t_filtered_px r;
        if (median_q.size() == 0) begin
            report($sformatf("result %h/%b with nothing expected", data, last));
        end else begin
            r = median_q.pop_front();
            for (int c = 0; c < NUM_CH; c++)
                if (data[8 * c +: 8] !== r.chans[8 * c +: 8])
                    report($sformatf("out_chan%0d got %h, expected %h", c, data[8 * c +: 8],
                                     r.chans[8 * c +: 8]));
            if (last !== r.frame_end)
                report($sformatf("frame_end got %b, expected %b", last, r.frame_end));
        end
    endtask

    // Result side: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
            if (hold_seen != hold_serial) begin
                hold_seen = hold_serial;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one request, with a random idle gap first, and predict it once accepted
    task automatic send_item(input logic func, input logic [31:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(func, data);
    endtask

    // Stop offering, wait for every result, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            med3_pkg::REG_WIDTH:    reg_width  = value[11:0];
            med3_pkg::REG_HEIGHT:   reg_height = value[15:0];
            med3_pkg::REG_CHANNELS: reg_chans  = value[2:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] expected);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== expected)
            report($sformatf("register %0d read %h, expected %h", idx, got, expected));
    endtask

    // New frame geometry, written only once the block is idle
    task automatic configure(input int w_raw, input int h_raw, input int ch_raw);
        settle();
        write_reg(med3_pkg::REG_WIDTH, w_raw);
        write_reg(med3_pkg::REG_HEIGHT, h_raw);
        write_reg(med3_pkg::REG_CHANNELS, ch_raw);
        check_reg(med3_pkg::REG_WIDTH, {20'd0, reg_width});
        check_reg(med3_pkg::REG_HEIGHT, {16'd0, reg_height});
        check_reg(med3_pkg::REG_CHANNELS, {29'd0, reg_chans});
    endtask

    task automatic test_reset_values();
        check_reg(med3_pkg::REG_WIDTH, 32'd640);
        check_reg(med3_pkg::REG_HEIGHT, 32'd480);
        check_reg(med3_pkg::REG_CHANNELS, 32'd1);
    endtask

    // Below 3x3 the pixels pass through; zero registers act as one
    task automatic test_small_image();
        configure(2, 2, 4);
        send_item(med3_pkg::FUNC_PIXEL, 32'h0000_0000);
        send_item(med3_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send_item(med3_pkg::FUNC_DRAIN, 32'hFFFF_FFFF);
        send_item(med3_pkg::FUNC_PIXEL, 32'hA55A_C33C);
        send_item(med3_pkg::FUNC_PIXEL, 32'h5AA5_3CC3);
        configure(0, 0, 0);
        send_item(med3_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send_item(med3_pkg::FUNC_PIXEL, 32'h1234_5678);
        settle();
    endtask

    // Smallest filtered frame with an early drain and a pixel among the drains
    task automatic test_min_frame();
        logic [31:0] pix [9];
        pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00, 32'h8040_2010,
                32'h0102_0408, 32'hFFFF_0000, 32'h0000_FFFF, 32'h7F80_01FE};
        configure(3, 3, 4);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_item(med3_pkg::FUNC_DRAIN, 32'hDEAD_BEEF);
            send_item(med3_pkg::FUNC_PIXEL, pix[i]);
        end
        send_item(med3_pkg::FUNC_DRAIN, 32'h0);
        send_item(med3_pkg::FUNC_PIXEL, 32'hFFFF_FFFF);
        send_item(med3_pkg::FUNC_DRAIN, 32'hFFFF_FFFF);
        send_item(med3_pkg::FUNC_DRAIN, 32'h0);
        settle();
    endtask

    // Register values past their range saturate; frames cut short by a restart
    task automatic test_oversized_regs();
        configure(12'hFFF, 1, 7);
        repeat (3) send_item(med3_pkg::FUNC_PIXEL, $urandom());
        configure(2, 16'hFFFF, 4);
        repeat (3) send_item(med3_pkg::FUNC_PIXEL, $urandom());
        settle();
    endtask

    // Mostly whole frames with random content; some noise and broken frames
    task automatic test_random_frames(input int idle, input int stall, input int target);
        int sel;
        int w_raw;
        int h_raw;
        int ch_raw;
        int w_eff;
        int h_eff;
        int n_pix;
        int sent;
        bit whole;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < target) begin
            sel   = $urandom_range(99);
            whole = 1'b1;
            if (sel < 70) begin
                w_raw = $urandom_range(3, 8);
                h_raw = $urandom_range(3, 5);
            end else if (sel < 80) begin
                w_raw = $urandom_range(9, 24);
                h_raw = $urandom_range(3, 4);
            end else if (sel < 90) begin
                if ($urandom_range(1)) begin
                    w_raw = $urandom_range(0, 2);
                    h_raw = $urandom_range(0, 5);
                end else begin
                    w_raw = $urandom_range(3, 8);
                    h_raw = $urandom_range(0, 2);
                end
            end else if (sel < 95) begin
                w_raw = $urandom_range(2049, 4095);
                h_raw = $urandom_range(1, 2);
                whole = 1'b0;
            end else begin
                w_raw = $urandom_range(3, 8);
                h_raw = $urandom_range(3, 5);
                whole = 1'b0;
            end
            ch_raw = ($urandom_range(99) < 85) ? $urandom_range(1, 4) :
                     ($urandom_range(1) ? 0 : $urandom_range(5, 7));
            configure(w_raw, h_raw, ch_raw);
            w_eff = eff_width();
            h_eff = eff_height();
            repeat ($urandom_range(1, 2)) begin
                n_pix = whole ? w_eff * h_eff : $urandom_range(4, 12);
                for (int p = 0; p < n_pix; p++) begin
                    if ($urandom_range(99) < 3) send_item(med3_pkg::FUNC_DRAIN, $urandom());
                    send_item(med3_pkg::FUNC_PIXEL, $urandom());
                    sent++;
                end
                if (!whole) break;
                if (w_eff >= 3 && h_eff >= 3) begin
                    for (int d = 0; d < w_eff; d++) begin
                        if ($urandom_range(99) < 5) send_item(med3_pkg::FUNC_PIXEL, $urandom());
                        send_item(med3_pkg::FUNC_DRAIN, $urandom());
                        sent++;
                    end
                end
            end
        end
        settle();
    endtask

    // Receiver holds off while a whole frame is offered back to back
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        configure(8, 6, 4);
        hold_serial++;
        repeat (48) send_item(med3_pkg::FUNC_PIXEL, $urandom());
        repeat (8) send_item(med3_pkg::FUNC_DRAIN, $urandom());
        settle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_small_image();
        test_min_frame();
        test_oversized_regs();
        test_random_frames(0, 0, 130);
        test_random_frames(78, 0, 130);
        test_random_frames(0, 78, 130);
        test_random_frames(7, 7, 130);
        test_backpressure();
        settle();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/med3_pkg.sv
src/median_3x3_filter_clamped_edges_unit.sv
tb/tb.sv
